// ----- hw/rtl/tcm_pkg.sv -----
// shared types and constants for the two-wire command and key-read master
// depends on nothing; imported by every module of the block
`default_nettype none

package tcm_pkg;

    // request codes on the opcode field
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ADDRESS_BASE = 2'd0;
    localparam logic [1:0] CFG_ADDRESS_MASK = 2'd1;
    localparam logic [1:0] CFG_KEY_COMMAND  = 2'd2;

    localparam logic [7:0]  RST_ADDRESS_BASE = 8'd64;
    localparam logic [7:0]  RST_ADDRESS_MASK = 8'd62;
    localparam logic [15:0] RST_KEY_COMMAND  = 16'd1792;

    // last phase number (counted from zero) of each transfer kind
    localparam logic [6:0] WRITE_LAST_PHASE = 7'd63;
    localparam logic [6:0] READ_LAST_PHASE  = 7'd73;

    localparam logic [7:0] READ_FLAG = 8'h01;

    typedef struct packed {
        logic [7:0]  address_base;
        logic [7:0]  address_mask;
        logic [15:0] key_command;
    } tcm_cfg_t;

    typedef struct packed {
        logic [6:0] phase;
        logic       kind;        // 0 write, 1 read
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] key;
        logic       clk_lvl;
        logic       dat_lvl;
        logic       drv_lvl;
    } tcm_state_t;

    typedef struct packed {
        logic key_valid;
        logic dropped;
    } tcm_flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/two_wire_command_keyread_master.sv -----
// top level of the two-wire command and key-read master
// depends on tcm_pkg, tcm_cfg_regs and tcm_phase_step
//
// usage: each input transaction carries an opcode. a write or read request
// loads a transfer; each following tick advances the bus by one pin phase
// and every input transaction returns exactly one result with the clock and
// data pin levels, busy flag, last key code and the key_valid and
// request_dropped flags. a write takes 64 ticks, a read 74 ticks.
// a transaction passes through the input register, then the result register.
// one transaction per cycle is sustained while the receiver takes results;
// the single pass of phase logic between those registers sets that figure.
// when the result receiver stalls, the result register holds; a full input
// register drops in_ready in that same cycle, an empty one still takes one
// transaction, so nothing is lost or reordered.
// config writes go through a separate channel that is always ready; the user
// makes them while no transaction is in flight, the block does not enforce it.
// reset: no transfer is active and the state holds clock high, data high,
// driven; the result registers, and so the pins, have no reset value.
`default_nettype none

module two_wire_command_keyread_master
    import tcm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [15:0] command_word,
    input  wire logic        data_pin_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             clock_pin,
    output logic             data_pin_out,
    output logic             data_drive,
    output logic             busy_res,
    output logic [7:0]       key_code,
    output logic             key_valid,
    output logic             request_dropped,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    tcm_cfg_t   cfg;
    tcm_state_t state_reg;
    tcm_state_t state_next;
    tcm_flags_t flags;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [1:0]  op_reg;
    logic [15:0] command_reg;
    logic        pin_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        step_go;
    logic        in_accept;

    logic       res_clk_reg;
    logic       res_dat_reg;
    logic       res_drv_reg;
    logic       res_busy_reg;
    logic [7:0] res_key_reg;
    logic       res_valid_reg;
    logic       res_dropped_reg;

    assign cfg_ready = 1'b1;

    tcm_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    tcm_phase_step u_step (
        .cfg          (cfg),
        .cur          (state_reg),
        .opcode       (op_reg),
        .command_word (command_reg),
        .data_pin_in  (pin_reg),
        .nxt          (state_next),
        .flags        (flags)
    );

    // a transaction in the input register runs once the result slot frees up
    assign step_go   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || step_go;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
            in_valid_next = 1'b1;
        else if (step_go)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step_go)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            state_reg.phase       <= 7'd0;
            state_reg.kind        <= 1'b0;
            state_reg.first_byte  <= 8'd0;
            state_reg.second_byte <= 8'd0;
            state_reg.key         <= 8'd0;
            state_reg.clk_lvl     <= 1'b1;
            state_reg.dat_lvl     <= 1'b1;
            state_reg.drv_lvl     <= 1'b1;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step_go)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg      <= opcode;
            command_reg <= command_word;
            pin_reg     <= data_pin_in;
        end
        if (step_go)
        begin
            res_clk_reg     <= state_next.clk_lvl;
            res_dat_reg     <= state_next.dat_lvl;
            res_drv_reg     <= state_next.drv_lvl;
            res_busy_reg    <= (state_next.phase != 7'd0);
            res_key_reg     <= state_next.key;
            res_valid_reg   <= flags.key_valid;
            res_dropped_reg <= flags.dropped;
        end
    end

    assign out_valid       = out_valid_reg;
    assign clock_pin       = res_clk_reg;
    assign data_pin_out    = res_dat_reg;
    assign data_drive      = res_drv_reg;
    assign busy_res        = res_busy_reg;
    assign key_code        = res_key_reg;
    assign key_valid       = res_valid_reg;
    assign request_dropped = res_dropped_reg;

`ifndef SYNTHESIS
    // a finished read leaves the master idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_valid |-> !busy_res)
        else $error("key_valid reported while still busy");

    // a tick cannot both finish a read and drop a request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(key_valid && request_dropped))
        else $error("key_valid and request_dropped in one result");

    // the output latch sits high whenever the data line is released
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !data_drive |-> data_pin_out)
        else $error("data latch low while line released");

    // the transfer state only moves when a transaction is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        !step_go |=> $stable(state_reg.phase))
        else $error("phase counter moved without a transaction");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/tcm_cfg_regs.sv -----
// configuration registers of the two-wire master
// depends on tcm_pkg
`default_nettype none

module tcm_cfg_regs
    import tcm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [15:0] wr_data,
    output tcm_cfg_t         cfg
);

    tcm_cfg_t cfg_reg;
    tcm_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_ADDRESS_BASE: cfg_next.address_base = wr_data[7:0];
                CFG_ADDRESS_MASK: cfg_next.address_mask = wr_data[7:0];
                CFG_KEY_COMMAND:  cfg_next.key_command  = wr_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.address_base <= RST_ADDRESS_BASE;
            cfg_reg.address_mask <= RST_ADDRESS_MASK;
            cfg_reg.key_command  <= RST_KEY_COMMAND;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/tcm_phase_step.sv -----
// next-state logic for one transaction: request load or one pin phase
// depends on tcm_pkg
`default_nettype none

module tcm_phase_step
    import tcm_pkg::*;
(
    input  wire tcm_cfg_t    cfg,
    input  wire tcm_state_t  cur,
    input  wire logic [1:0]  opcode,
    input  wire logic [15:0] command_word,
    input  wire logic        data_pin_in,
    output tcm_state_t       nxt,
    output tcm_flags_t       flags
);

    logic       busy;
    logic [6:0] q;
    logic [6:0] last_phase;
    logic [5:0] r;
    logic [1:0] r_sub;
    logic [4:0] w;
    logic [7:0] w_byte;
    logic       in_write;
    logic [8:0] w_times11;
    logic [2:0] w_bit;
    logic [4:0] w_sub;
    logic [7:0] masked;
    logic [1:0] stop_sub;

    always_comb
    begin
        busy       = (cur.phase != 7'd0);
        q          = cur.phase - 7'd1;
        last_phase = cur.kind ? READ_LAST_PHASE : WRITE_LAST_PHASE;
        r          = q[5:0] - 6'd32;
        r_sub      = r[1:0] + 2'd1;     // (r - 3) mod 4
        in_write   = 1'b0;
        w          = 5'd0;
        w_byte     = cur.first_byte;
        stop_sub   = cur.kind ? (q[1:0] + 2'd2) : q[1:0];

        if (q >= 7'd4 && q < 7'd32)
        begin
            in_write = 1'b1;
            w        = 5'(q - 7'd4);
            w_byte   = cur.first_byte;
        end
        else if (!cur.kind && q >= 7'd32 && q < 7'd60)
        begin
            in_write = 1'b1;
            w        = q[4:0];
            w_byte   = cur.second_byte;
        end

        // bit index is w / 3 for w below 24
        w_times11 = {4'd0, w} * 9'd11;
        w_bit     = w_times11[7:5];
        w_sub     = w - ({2'd0, w_bit} + {1'b0, w_bit, 1'b0});

        masked = (command_word[14:7] & cfg.address_mask) | cfg.address_base;

        nxt   = cur;
        flags = '0;

        case (opcode)
            OP_WRITE, OP_READ:
            begin
                if (busy)
                begin
                    flags.dropped = 1'b1;
                end
                else if (opcode == OP_READ)
                begin
                    nxt.kind        = 1'b1;
                    nxt.first_byte  = (cfg.key_command[14:7] & cfg.address_mask)
                                      | READ_FLAG | cfg.address_base;
                    nxt.second_byte = 8'd0;
                    nxt.phase       = 7'd1;
                end
                else
                begin
                    nxt.kind        = 1'b0;
                    nxt.first_byte  = masked;
                    nxt.second_byte = command_word[7:0];
                    nxt.phase       = 7'd1;
                end
            end
            OP_TICK:
            begin
                if (busy)
                begin
                    if (q < 7'd4)
                    begin
                        // start condition
                        case (q[1:0])
                            2'd0:
                            begin
                                nxt.drv_lvl = 1'b1;
                                nxt.clk_lvl = 1'b1;
                            end
                            2'd1:    nxt.dat_lvl = 1'b1;
                            2'd2:    nxt.dat_lvl = 1'b0;
                            default: nxt.clk_lvl = 1'b0;
                        endcase
                    end
                    else if (in_write)
                    begin
                        nxt.drv_lvl = 1'b1;
                        if (w < 5'd24)
                        begin
                            if (w_sub == 5'd0)
                                nxt.dat_lvl = w_byte[~w_bit];
                            else if (w_sub == 5'd1)
                                nxt.clk_lvl = 1'b1;
                            else
                                nxt.clk_lvl = 1'b0;
                        end
                        else if (w == 5'd25)
                            nxt.dat_lvl = 1'b1;
                        else if (w == 5'd26)
                            nxt.clk_lvl = 1'b1;
                        else if (w == 5'd27)
                            nxt.clk_lvl = 1'b0;
                    end
                    else if (cur.kind && q < 7'd70)
                    begin
                        // released data line, eight clocked samples, answer bit
                        if (r == 6'd0)
                            nxt.dat_lvl = 1'b1;
                        else if (r == 6'd1)
                            nxt.drv_lvl = 1'b0;
                        else if (r == 6'd2)
                            nxt.clk_lvl = 1'b0;
                        else if (r < 6'd35)
                        begin
                            if (r_sub == 2'd0)
                                nxt.clk_lvl = 1'b1;
                            else if (r_sub == 2'd2)
                                nxt.second_byte = {cur.second_byte[6:0], data_pin_in};
                            else if (r_sub == 2'd3)
                                nxt.clk_lvl = 1'b0;
                        end
                        else if (r == 6'd35)
                        begin
                            nxt.drv_lvl = 1'b1;
                            nxt.dat_lvl = 1'b1;
                        end
                        else if (r == 6'd36)
                            nxt.clk_lvl = 1'b1;
                        else
                            nxt.clk_lvl = 1'b0;
                    end
                    else
                    begin
                        // stop condition
                        case (stop_sub)
                            2'd0:
                            begin
                                nxt.drv_lvl = 1'b1;
                                nxt.clk_lvl = 1'b0;
                            end
                            2'd1:    nxt.dat_lvl = 1'b0;
                            2'd2:    nxt.clk_lvl = 1'b1;
                            default: nxt.dat_lvl = 1'b1;
                        endcase
                    end

                    if (q >= last_phase)
                    begin
                        nxt.phase = 7'd0;
                        if (cur.kind)
                        begin
                            nxt.key         = nxt.second_byte;
                            flags.key_valid = 1'b1;
                        end
                    end
                    else
                    begin
                        nxt.phase = cur.phase + 7'd1;
                    end
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire
